// File: rtl/box_average_downscale_unit_defines.svh
// Assertion macros for the box average downscaler checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef BOX_AVERAGE_DOWNSCALE_UNIT_DEFINES_SVH
`define BOX_AVERAGE_DOWNSCALE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BOXDS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define BOXDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/boxds_pkg.sv
// Shared constants, register indexes and types for the box average downscaler.
// No dependencies; imported by the interfaces, the top level, front, back and checker.
package boxds_pkg;

  localparam int DEF_MAX_WIDTH    = 4096;
  localparam int DEF_MAX_FACTOR   = 16;
  localparam int DEF_MAX_CHANNELS = 4;

  localparam int NUM_LANES    = 4;
  localparam int PIX_W        = 8;
  localparam int SUM_W        = 16;
  localparam int POS_W        = 12;
  localparam int ROW_W        = 13;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [PIX_W-1:0] AVG_MAX = '1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

  localparam logic [4:0]  RST_BLOCK_HEIGHT  = 5'd1;
  localparam logic [4:0]  RST_BLOCK_WIDTH   = 5'd1;
  localparam logic [12:0] RST_FRAME_WIDTH   = 13'd4096;
  localparam logic [12:0] RST_FRAME_HEIGHT  = 13'd4096;
  localparam logic [2:0]  RST_CHANNEL_COUNT = 3'd3;

  typedef logic [NUM_LANES-1:0][PIX_W-1:0] pix_t;
  typedef logic [NUM_LANES-1:0][SUM_W-1:0] sum_t;

  typedef struct packed {
    logic                 first;
    logic                 last;
    logic                 done;
    logic [NUM_LANES-1:0] chan_en;
  } item_flags_t;

endpackage

// File: rtl/boxds_if.sv
// Valid/ready channel interfaces for pixels in and averaged pixels out.
// Depends on boxds_pkg.
interface boxds_in_if import boxds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] chan_a;
  logic [PIX_W-1:0] chan_b;
  logic [PIX_W-1:0] chan_c;
  logic [PIX_W-1:0] chan_d;

  modport source (output valid, chan_a, chan_b, chan_c, chan_d, input ready);
  modport sink (input valid, chan_a, chan_b, chan_c, chan_d, output ready);
endinterface

interface boxds_out_if import boxds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic [PIX_W-1:0] avg_a;
  logic [PIX_W-1:0] avg_b;
  logic [PIX_W-1:0] avg_c;
  logic [PIX_W-1:0] avg_d;
  logic             frame_done;

  modport source (output valid, out_row, out_col, avg_a, avg_b, avg_c, avg_d, frame_done,
                  input ready);
  modport sink (input valid, out_row, out_col, avg_a, avg_b, avg_c, avg_d, frame_done,
                output ready);
endinterface

// File: rtl/box_average_downscale_unit.sv
// Top level of the box-filter area-average downscaler: front, queue, line store, back.
// Depends on boxds_pkg, boxds_if, boxds_ram, boxds_queue, boxds_front, boxds_back.
//
//   channel   | direction | handshake        | payload
//   ----------+-----------+------------------+-----------------------------------------
//   in_if     | in        | valid / ready    | chan_a..chan_d, 8 bits each
//   out_if    | out       | valid / ready    | out_row, out_col, avg_a..avg_d, frame_done
//   cfg_*     | in        | cfg_we only      | cfg_index, cfg_data
//
// A pixel inside a whole block passes through the line store read-modify-write;
// the pixel that closes a block then holds the back while its sum is finished, run
// through the per-channel bit-serial divider and presented until out_if.ready.
// Pixels of partial edge blocks are dropped at once. After reset and after each
// cfg write, in_if.ready stays low while the output grid size is divided out.
// A four-deep queue lets the front keep taking pixels while a result waits.
module box_average_downscale_unit import boxds_pkg::*; #(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR   = DEF_MAX_FACTOR,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  boxds_in_if.sink              in_if,
  boxds_out_if.source           out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int AREA_W = 2 * $clog2(MAX_FACTOR + 1);
  localparam int ITEM_W = $bits(item_flags_t) + ADDR_W + AREA_W + 2 * POS_W + $bits(pix_t);

  pix_t              in_pix;
  logic              push, q_full, q_pop, q_empty;
  item_flags_t       push_flags, q_flags;
  logic [ADDR_W-1:0] push_addr, q_addr;
  logic [AREA_W-1:0] push_area, q_area;
  logic [POS_W-1:0]  push_row, push_col, q_row, q_col;
  pix_t              push_pix, q_pix;
  logic [ITEM_W-1:0] q_head;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  sum_t              ram_wdata, ram_rdata;
  pix_t              out_avg;

  assign in_pix = {in_if.chan_d, in_if.chan_c, in_if.chan_b, in_if.chan_a};

  boxds_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_FACTOR   (MAX_FACTOR),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_pix     (in_pix),
    .q_full     (q_full),
    .push       (push),
    .push_flags (push_flags),
    .push_addr  (push_addr),
    .push_area  (push_area),
    .push_row   (push_row),
    .push_col   (push_col),
    .push_pix   (push_pix)
  );

  boxds_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_flags, push_addr, push_area, push_row, push_col, push_pix}),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  assign {q_flags, q_addr, q_area, q_row, q_col, q_pix} = q_head;

  boxds_ram #(
    .WIDTH ($bits(sum_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  boxds_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_flags   (q_flags),
    .q_addr    (q_addr),
    .q_area    (q_area),
    .q_row     (q_row),
    .q_col     (q_col),
    .q_pix     (q_pix),
    .q_pop     (q_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_row   (out_if.out_row),
    .out_col   (out_if.out_col),
    .out_avg   (out_avg),
    .out_done  (out_if.frame_done)
  );

  assign out_if.avg_a = out_avg[0];
  assign out_if.avg_b = out_avg[1];
  assign out_if.avg_c = out_avg[2];
  assign out_if.avg_d = out_avg[3];

endmodule

// File: rtl/boxds_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module boxds_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/boxds_queue.sv
// Small register FIFO that decouples the classify front from the accumulate back.
// No dependencies; DEPTH must be a power of two, at least two.
module boxds_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/boxds_front.sv
// Front end: configuration registers, output-grid size, raster position counters
// and block classification of each pixel. Depends on boxds_pkg.
module boxds_front import boxds_pkg::*; #(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR   = DEF_MAX_FACTOR,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  localparam int ADDR_W = $clog2(MAX_WIDTH),
  localparam int AREA_W = 2 * $clog2(MAX_FACTOR + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pix_t                  in_pix,
  input  logic                  q_full,
  output logic                  push,
  output item_flags_t           push_flags,
  output logic [ADDR_W-1:0]     push_addr,
  output logic [AREA_W-1:0]     push_area,
  output logic [POS_W-1:0]      push_row,
  output logic [POS_W-1:0]      push_col,
  output pix_t                  push_pix
);

  localparam int FACT_W = $clog2(MAX_FACTOR + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int BC_W   = COL_W + 1;
  localparam int BR_W   = ROW_W + 1;
  localparam int DV_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int DC_W   = $clog2(DV_W + 1);

  logic [4:0]  bh_r, bw_r;
  logic [12:0] fw_r, fh_r;
  logic [2:0]  cc_r;

  logic [FACT_W-1:0]    bh, bw;
  logic [COL_W-1:0]     fw;
  logic [ROW_W-1:0]     fh;
  logic [2:0]           cc;
  logic [NUM_LANES-1:0] chan_en;

  logic              dv_ld_r, dv_run_r;
  logic [DC_W-1:0]   dv_cnt_r;
  logic [DV_W-1:0]   w_quo_r, h_quo_r;
  logic [FACT_W-1:0] w_rem_r, h_rem_r;
  logic [FACT_W:0]   w_sh, h_sh;
  logic              w_ge, h_ge;
  logic [COL_W-1:0]  out_w;
  logic [ROW_W-1:0]  out_h;

  logic [COL_W-1:0]  in_col_r, ic_w, ic_nxt;
  logic [ROW_W-1:0]  in_row_r, ir_w, ir_nxt;
  logic [FACT_W-1:0] cib_r, cib_w, cib_nxt;
  logic [FACT_W-1:0] rib_r, rib_w, rib_nxt;
  logic [BC_W-1:0]   bcol_r, bcol_nxt;
  logic [BR_W-1:0]   brow_r, brow_nxt;
  logic              blk_ok, accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bh_r <= RST_BLOCK_HEIGHT;
      bw_r <= RST_BLOCK_WIDTH;
      fw_r <= RST_FRAME_WIDTH;
      fh_r <= RST_FRAME_HEIGHT;
      cc_r <= RST_CHANNEL_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_HEIGHT:  bh_r <= cfg_data[4:0];
        REG_BLOCK_WIDTH:   bw_r <= cfg_data[4:0];
        REG_FRAME_WIDTH:   fw_r <= cfg_data;
        REG_FRAME_HEIGHT:  fh_r <= cfg_data;
        REG_CHANNEL_COUNT: cc_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // clamp registers into their legal ranges
  always_comb begin
    if (bh_r == '0) bh = FACT_W'(1);
    else if (32'(bh_r) > MAX_FACTOR) bh = FACT_W'(MAX_FACTOR);
    else bh = FACT_W'(bh_r);
    if (bw_r == '0) bw = FACT_W'(1);
    else if (32'(bw_r) > MAX_FACTOR) bw = FACT_W'(MAX_FACTOR);
    else bw = FACT_W'(bw_r);
    if (fw_r == '0) fw = COL_W'(1);
    else if (32'(fw_r) > MAX_WIDTH) fw = COL_W'(MAX_WIDTH);
    else fw = COL_W'(fw_r);
    if (fh_r == '0) fh = ROW_W'(1);
    else if (32'(fh_r) > HEIGHT_LIMIT) fh = ROW_W'(HEIGHT_LIMIT);
    else fh = ROW_W'(fh_r);
    if (cc_r == '0) cc = 3'd1;
    else if (32'(cc_r) > MAX_CHANNELS) cc = 3'(MAX_CHANNELS);
    else cc = cc_r;
    for (int i = 0; i < NUM_LANES; i++) begin
      chan_en[i] = (32'(cc) > i);
    end
  end

  // bit-serial division of frame size by block size, rerun on every write
  always_comb begin
    w_sh  = {w_rem_r, w_quo_r[DV_W-1]};
    h_sh  = {h_rem_r, h_quo_r[DV_W-1]};
    w_ge  = (w_sh >= {1'b0, bw});
    h_ge  = (h_sh >= {1'b0, bh});
    out_w = COL_W'(w_quo_r);
    out_h = ROW_W'(h_quo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_ld_r  <= 1'b1;
      dv_run_r <= 1'b0;
      dv_cnt_r <= '0;
    end else if (cfg_we) begin
      dv_ld_r  <= 1'b1;
      dv_run_r <= 1'b0;
    end else if (dv_ld_r) begin
      dv_ld_r  <= 1'b0;
      dv_run_r <= 1'b1;
      dv_cnt_r <= '0;
    end else if (dv_run_r) begin
      dv_cnt_r <= dv_cnt_r + DC_W'(1);
      if (dv_cnt_r == DC_W'(DV_W - 1)) begin
        dv_run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ld_r) begin
      w_quo_r <= DV_W'(fw);
      h_quo_r <= DV_W'(fh);
      w_rem_r <= '0;
      h_rem_r <= '0;
    end else if (dv_run_r) begin
      w_quo_r <= {w_quo_r[DV_W-2:0], w_ge};
      h_quo_r <= {h_quo_r[DV_W-2:0], h_ge};
      w_rem_r <= w_ge ? FACT_W'(w_sh - {1'b0, bw}) : FACT_W'(w_sh);
      h_rem_r <= h_ge ? FACT_W'(h_sh - {1'b0, bh}) : FACT_W'(h_sh);
    end
  end

  // classify and advance position
  always_comb begin
    cib_w = (cib_r >= bw) ? '0 : cib_r;
    rib_w = (rib_r >= bh) ? '0 : rib_r;
    ic_w  = (in_col_r >= fw) ? '0 : in_col_r;
    ir_w  = (in_row_r >= fh) ? '0 : in_row_r;

    blk_ok = (bcol_r < BC_W'(out_w)) && (brow_r < BR_W'(out_h));
    push_flags.first   = (rib_w == '0) && (cib_w == '0);
    push_flags.last    = (rib_w + FACT_W'(1) == bh) && (cib_w + FACT_W'(1) == bw);
    push_flags.done    = (bcol_r + BC_W'(1) == BC_W'(out_w)) &&
                         (brow_r + BR_W'(1) == BR_W'(out_h));
    push_flags.chan_en = chan_en;

    cib_nxt  = cib_w + FACT_W'(1);
    bcol_nxt = bcol_r;
    if (cib_nxt >= bw) begin
      cib_nxt  = '0;
      bcol_nxt = bcol_r + BC_W'(1);
    end
    ic_nxt   = ic_w + COL_W'(1);
    ir_nxt   = ir_w;
    rib_nxt  = rib_w;
    brow_nxt = brow_r;
    if (ic_nxt >= fw) begin
      ic_nxt   = '0;
      cib_nxt  = '0;
      bcol_nxt = '0;
      ir_nxt   = ir_w + ROW_W'(1);
      rib_nxt  = rib_w + FACT_W'(1);
      if (rib_nxt >= bh) begin
        rib_nxt  = '0;
        brow_nxt = brow_r + BR_W'(1);
      end
      if (ir_nxt >= fh) begin
        ir_nxt   = '0;
        rib_nxt  = '0;
        brow_nxt = '0;
      end
    end
  end

  assign in_ready = !dv_ld_r && !dv_run_r && !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && blk_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
      cib_r    <= '0;
      rib_r    <= '0;
      bcol_r   <= '0;
      brow_r   <= '0;
    end else if (accept) begin
      in_col_r <= ic_nxt;
      in_row_r <= ir_nxt;
      cib_r    <= cib_nxt;
      rib_r    <= rib_nxt;
      bcol_r   <= bcol_nxt;
      brow_r   <= brow_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      push_pix[i] = chan_en[i] ? in_pix[i] : '0;
    end
    push_addr = ADDR_W'(bcol_r);
    push_area = AREA_W'(bh) * AREA_W'(bw);
    push_row  = POS_W'(brow_r);
    push_col  = POS_W'(bcol_r);
  end

endmodule

// File: rtl/boxds_back.sv
// Back end: read-modify-write of the column line store, area division and
// the output register. Depends on boxds_pkg; drives one boxds_ram.
module boxds_back import boxds_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = DEF_MAX_FACTOR,
  localparam int ADDR_W = $clog2(MAX_WIDTH),
  localparam int AREA_W = 2 * $clog2(MAX_FACTOR + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  item_flags_t       q_flags,
  input  logic [ADDR_W-1:0] q_addr,
  input  logic [AREA_W-1:0] q_area,
  input  logic [POS_W-1:0]  q_row,
  input  logic [POS_W-1:0]  q_col,
  input  pix_t              q_pix,
  output logic              q_pop,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output sum_t              ram_wdata,
  output logic [ADDR_W-1:0] ram_raddr,
  input  sum_t              ram_rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [POS_W-1:0]  out_row,
  output logic [POS_W-1:0]  out_col,
  output pix_t              out_avg,
  output logic              out_done
);

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_OUT = 2'd2;
  localparam int CNT_W = $clog2(SUM_W);

  logic [1:0]       state_r;
  logic [CNT_W-1:0] cnt_r;

  logic              s1_vld_r, s1_fwd_r;
  item_flags_t       s1_flags_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [AREA_W-1:0] s1_area_r;
  logic [POS_W-1:0]  s1_row_r, s1_col_r;
  pix_t              s1_pix_r;
  sum_t              fwd_sum_r;
  sum_t              prev, wsum;

  sum_t                                 dv_quo_r;
  logic [NUM_LANES-1:0][AREA_W-1:0]     dv_rem_r;
  logic [AREA_W-1:0]                    dv_area_r;
  logic [NUM_LANES-1:0][AREA_W:0]       dv_sh;
  logic [NUM_LANES-1:0]                 dv_ge;
  logic [POS_W-1:0]                     res_row_r, res_col_r;
  logic                                 res_done_r;
  logic [NUM_LANES-1:0]                 res_en_r;

  logic [SUM_W:0] acc;

  assign q_pop = (state_r == ST_RUN) && !q_empty && !(s1_vld_r && s1_flags_r.last);

  // accumulate, forwarding the entry written last cycle
  always_comb begin
    prev = s1_fwd_r ? fwd_sum_r : ram_rdata;
    for (int c = 0; c < NUM_LANES; c++) begin
      acc = (s1_flags_r.first ? {(SUM_W + 1){1'b0}} : {1'b0, prev[c]}) +
            (SUM_W + 1)'(s1_pix_r[c]);
      wsum[c] = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
    end
  end

  assign ram_we    = s1_vld_r;
  assign ram_waddr = s1_addr_r;
  assign ram_wdata = wsum;
  assign ram_raddr = q_addr;

  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      dv_sh[c] = {dv_rem_r[c], dv_quo_r[c][SUM_W-1]};
      dv_ge[c] = (dv_sh[c] >= {1'b0, dv_area_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_RUN;
      s1_vld_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      s1_vld_r <= q_pop;
      unique case (state_r)
        ST_RUN: begin
          cnt_r <= '0;
          if (s1_vld_r && s1_flags_r.last) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(SUM_W - 1)) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            state_r <= ST_RUN;
          end
        end
        default: state_r <= ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_flags_r <= q_flags;
      s1_addr_r  <= q_addr;
      s1_area_r  <= q_area;
      s1_row_r   <= q_row;
      s1_col_r   <= q_col;
      s1_pix_r   <= q_pix;
      s1_fwd_r   <= s1_vld_r && (q_addr == s1_addr_r);
    end
    if (s1_vld_r) begin
      fwd_sum_r <= wsum;
    end
    if (s1_vld_r && s1_flags_r.last && state_r == ST_RUN) begin
      dv_quo_r   <= wsum;
      dv_rem_r   <= '0;
      dv_area_r  <= s1_area_r;
      res_row_r  <= s1_row_r;
      res_col_r  <= s1_col_r;
      res_done_r <= s1_flags_r.done;
      res_en_r   <= s1_flags_r.chan_en;
    end else if (state_r == ST_DIV) begin
      for (int c = 0; c < NUM_LANES; c++) begin
        dv_quo_r[c] <= {dv_quo_r[c][SUM_W-2:0], dv_ge[c]};
        dv_rem_r[c] <= dv_ge[c] ? AREA_W'(dv_sh[c] - {1'b0, dv_area_r}) : AREA_W'(dv_sh[c]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      if (!res_en_r[c]) out_avg[c] = '0;
      else if (|dv_quo_r[c][SUM_W-1:PIX_W]) out_avg[c] = AVG_MAX;
      else out_avg[c] = dv_quo_r[c][PIX_W-1:0];
    end
  end

  assign out_valid = (state_r == ST_OUT);
  assign out_row   = res_row_r;
  assign out_col   = res_col_r;
  assign out_done  = res_done_r;

endmodule

// File: rtl/boxds_checker.sv
// Port-level checker for the box average downscaler, bound to the top level.
// Depends on boxds_pkg and box_average_downscale_unit_defines.svh.
`include "box_average_downscale_unit_defines.svh"

module boxds_checker import boxds_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [POS_W-1:0] out_row,
  input logic [POS_W-1:0] out_col,
  input logic             cfg_we
);

  // hold a stalled result in place
  `BOXDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_row) && $stable(out_col), "result changed while stalled")
  // hold off input while the grid size is recomputed
  `BOXDS_ASSERT_NEXT(a_cfg_holdoff, cfg_we, !in_ready, "item taken during grid recompute")
  // one result at a time: each block's result goes through the divider first
  `BOXDS_ASSERT_NEXT(a_result_gap, out_valid && out_ready, !out_valid, "results closer than the divider allows")
  // no item is taken during back-to-back cfg writes
  `BOXDS_ASSERT_SAME(a_in_quiet, cfg_we, !(in_valid && in_ready && $past(cfg_we)), "item taken right after a write")

endmodule

bind box_average_downscale_unit boxds_checker u_boxds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_row   (out_if.out_row),
  .out_col   (out_if.out_col),
  .cfg_we    (cfg_we)
);
